[sv/multi_window_region_mean_top_macros.svh]
// Assertion macros used by the multi-window region mean top level
`ifndef MULTI_WINDOW_REGION_MEAN_TOP_MACROS_SVH
`define MULTI_WINDOW_REGION_MEAN_TOP_MACROS_SVH

// same-cycle implication
`define MWRM_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define MWRM_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[sv/mwrm_pkg.sv]
// Package: constants, codes and types of the multi-window region mean block
package mwrm_pkg;

    localparam int IMAGE_SIZE   = 1920;
    localparam int WINDOW_HALF  = 10;
    localparam int REGION_COUNT = 21;
    localparam int ACROSS_COUNT = 3;
    localparam int ALONG_COUNT  = 7;

    localparam int PIX_W      = 16;
    localparam int POS_W      = $clog2(IMAGE_SIZE);
    localparam int EDGE_W     = 2;
    localparam int OVL_W      = 11;
    localparam int SHIFT_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int IDX_W      = $clog2(REGION_COUNT);
    localparam int CNT_W      = $clog2(REGION_COUNT + 1);

    // signed center coordinates and magnitudes of center differences
    localparam int CTR_W = POS_W + 2;
    localparam int MAG_W = CTR_W - 1;

    // truncating divide by three through a reciprocal
    localparam int    DIV3_SHIFT  = MAG_W + 2;
    localparam int    DIV3_MULT_W = DIV3_SHIFT - 1;
    localparam longint DIV3_MULT  = ((64'd1 << DIV3_SHIFT) + 2) / 3;

    // window area, sum saturation and rounded-mean reciprocal
    localparam int     WIN_AREA    = 4 * WINDOW_HALF * WINDOW_HALF;
    localparam longint SUM_LIMIT   = longint'(WIN_AREA) * 65535;
    localparam int     SUM_W       = $clog2(SUM_LIMIT + 1);
    localparam int     MEAN_SHIFT  = SUM_W + 1 + $clog2(WIN_AREA);
    localparam int     MEAN_MULT_W = MEAN_SHIFT - $clog2(WIN_AREA) + 1;
    localparam longint MEAN_MULT   = ((64'd1 << MEAN_SHIFT) + WIN_AREA - 1) / WIN_AREA;

    // edge side codes
    localparam logic [EDGE_W-1:0] EDGE_LEFT  = EDGE_W'(0);
    localparam logic [EDGE_W-1:0] EDGE_RIGHT = EDGE_W'(1);
    localparam logic [EDGE_W-1:0] EDGE_DOWN  = EDGE_W'(2);
    localparam logic [EDGE_W-1:0] EDGE_UP    = EDGE_W'(3);

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_SIDE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_WIDTH = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_LATERAL_SHIFT = CFG_IDX_W'(2);

    localparam logic [EDGE_W-1:0]  EDGE_RESET  = EDGE_LEFT;
    localparam logic [OVL_W-1:0]   OVL_RESET   = OVL_W'(294);
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(0);

    typedef logic signed [CTR_W-1:0] ctr_t;
    typedef logic [SUM_W-1:0]        sum_t;

    // one pixel as it travels down the input pipeline to the cells
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pix;
        logic             last;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } pix_beat_t;

    // result chain control
    typedef struct packed {
        logic load;
        logic shift;
    } chain_ctl_t;

    // one finished window sum on its way to the mean stage
    typedef struct packed {
        logic             valid;
        sum_t             sum;
        logic [IDX_W-1:0] index;
        logic             last;
    } drain_item_t;

endpackage

[sv/mwrm_pixel_if.sv]
// Interface: pixel input channel
interface mwrm_pixel_if import mwrm_pkg::*;
    ;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    logic             plane_end;

    modport source (output valid, output pixel_value, output plane_end, input ready);
    modport sink   (input valid, input pixel_value, input plane_end, output ready);
endinterface

[sv/mwrm_result_if.sv]
// Interface: region mean result channel
interface mwrm_result_if import mwrm_pkg::*;
    ;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] region_index;
    logic [PIX_W-1:0] region_mean;
    logic             last_region;

    modport source (output valid, output region_index, output region_mean,
                    output last_region, input ready);
    modport sink   (input valid, input region_index, input region_mean,
                    input last_region, output ready);
endinterface

[sv/multi_window_region_mean_top.sv]
// Top level of the multi-window region mean block
//
// Takes one pixel per clock in raster order and keeps 21 window sums in a row of
// cells, one cell per window. A pixel passes the input pipeline registers on its
// way to the cells, as many as a write passes through the configuration registers
// and the center placement pipeline, so a configuration write applies to every
// pixel accepted after it. At the pixel marked plane_end every cell drops its
// final sum into its stage of a result chain and restarts from zero; the chain
// shifts one sum per cycle into the rounded-mean unit while that unit can take
// it, so the 21 results come out in window order, one per cycle while the sink
// takes them. Pixels keep streaming during that drain; only a further plane_end
// waits until the chain has emptied. Reset clears the sums directly, with no
// clearing pass.
`include "multi_window_region_mean_top_macros.svh"

module multi_window_region_mean_top import mwrm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mwrm_pixel_if.sink            pixel_in,
    mwrm_result_if.source         result_out
);

    localparam int PIPE_DEPTH = 4;

    // configuration
    logic [EDGE_W-1:0]  edge_side_reg;
    logic [OVL_W-1:0]   overlap_width_reg;
    logic [SHIFT_W-1:0] lateral_shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_side_reg     <= EDGE_RESET;
            overlap_width_reg <= OVL_RESET;
            lateral_shift_reg <= SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EDGE_SIDE:     edge_side_reg     <= cfg_data[EDGE_W-1:0];
                CFG_OVERLAP_WIDTH: overlap_width_reg <= cfg_data[OVL_W-1:0];
                CFG_LATERAL_SHIFT: lateral_shift_reg <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    ctr_t cx [REGION_COUNT];
    ctr_t cy [REGION_COUNT];

    mwrm_place u_place (
        .clk           (clk),
        .edge_side     (edge_side_reg),
        .overlap_width (overlap_width_reg),
        .lateral_shift (lateral_shift_reg),
        .cx            (cx),
        .cy            (cy)
    );

    // input transaction, raster position and pixel pipeline
    logic             accept, end_in_flight;
    logic [POS_W-1:0] col_reg, row_reg, col_next, row_next;
    logic [CNT_W-1:0] remaining_reg, remaining_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    pix_beat_t        beat_next;
    pix_beat_t        beat_reg [PIPE_DEPTH];
    pix_beat_t        tail;
    chain_ctl_t       ctl;
    drain_item_t      drain;
    logic             drain_ready;
    sum_t             chain [REGION_COUNT + 1];

    always_comb
    begin
        end_in_flight = 1'b0;
        for (int j = 0; j < PIPE_DEPTH; j++)
            end_in_flight = end_in_flight || (beat_reg[j].valid && beat_reg[j].last);
    end

    assign pixel_in.ready = !(pixel_in.plane_end && (end_in_flight || remaining_reg != '0));
    assign accept = pixel_in.valid && pixel_in.ready;

    always_comb
    begin
        beat_next.valid = accept;
        beat_next.pix   = pixel_in.pixel_value;
        beat_next.last  = pixel_in.plane_end;
        beat_next.col   = col_reg;
        beat_next.row   = row_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (pixel_in.plane_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_reg == POS_W'(IMAGE_SIZE - 1))
            begin
                col_next = '0;
                row_next = (row_reg == POS_W'(IMAGE_SIZE - 1)) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    assign tail = beat_reg[PIPE_DEPTH-1];

    // result chain drain
    always_comb
    begin
        ctl.load  = tail.valid && tail.last;
        ctl.shift = (remaining_reg != '0) && drain_ready;
        drain.valid = remaining_reg != '0;
        drain.sum   = chain[0];
        drain.index = idx_reg;
        drain.last  = idx_reg == IDX_W'(REGION_COUNT - 1);
        remaining_next = remaining_reg;
        idx_next       = idx_reg;
        if (ctl.load)
        begin
            remaining_next = CNT_W'(REGION_COUNT);
            idx_next       = '0;
        end
        else if (ctl.shift)
        begin
            remaining_next = remaining_reg - 1'b1;
            idx_next       = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            remaining_reg <= '0;
            idx_reg       <= '0;
            for (int j = 0; j < PIPE_DEPTH; j++)
                beat_reg[j] <= '0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            remaining_reg <= remaining_next;
            idx_reg       <= idx_next;
            beat_reg[0]   <= beat_next;
            for (int j = 1; j < PIPE_DEPTH; j++)
                beat_reg[j] <= beat_reg[j-1];
        end
    end

    assign chain[REGION_COUNT] = '0;

    for (genvar g = 0; g < REGION_COUNT; g++)
    begin : g_cell
        mwrm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .beat      (tail),
            .cx        (cx[g]),
            .cy        (cy[g]),
            .ctl       (ctl),
            .chain_in  (chain[g+1]),
            .chain_out (chain[g])
        );
    end

    mwrm_mean u_mean (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (drain),
        .item_ready (drain_ready),
        .result_out (result_out)
    );

    `MWRM_ASSERT_IMPLY(a_load_into_empty_chain, clk, rst_n, ctl.load, remaining_reg == '0,
        "plane end reached the cells while the result chain was still draining")
    `MWRM_ASSERT_NEXT(a_load_fills_chain, clk, rst_n, ctl.load,
        remaining_reg == CNT_W'(REGION_COUNT) && idx_reg == '0,
        "result chain not filled after plane end")
    `MWRM_ASSERT_IMPLY(a_last_is_final_window, clk, rst_n,
        result_out.valid && result_out.last_region,
        result_out.region_index == IDX_W'(REGION_COUNT - 1),
        "last_region flagged on a window other than the final one")

endmodule

[sv/mwrm_place.sv]
// Window center placement: three-stage pipeline from the configuration registers
module mwrm_place import mwrm_pkg::*;
(
    input  logic               clk,
    input  logic [EDGE_W-1:0]  edge_side,
    input  logic [OVL_W-1:0]   overlap_width,
    input  logic [SHIFT_W-1:0] lateral_shift,
    output ctr_t               cx [REGION_COUNT],
    output ctr_t               cy [REGION_COUNT]
);

    localparam int DIV3_PROD_W = DIV3_SHIFT + MAG_W;

    function automatic ctr_t half_trunc(ctr_t x);
        return (x + ctr_t'(x[CTR_W-1])) >>> 1;
    endfunction

    // stage 1: end points and differences
    ctr_t              n, h, ov, s;
    logic              far_across, minus_shift;
    ctr_t              across_s1_next [ACROSS_COUNT];
    ctr_t              a0_s1_next, a3_s1_next, a6_s1_next, d1, d2, d1_neg_v, d2_neg_v;

    ctr_t              across_s1_reg [ACROSS_COUNT];
    ctr_t              a0_s1_reg, a3_s1_reg, a6_s1_reg;
    logic [MAG_W-1:0]  d1_mag_s1_reg, d2_mag_s1_reg;
    logic              d1_neg_s1_reg, d2_neg_s1_reg;
    logic [EDGE_W-1:0] es_s1_reg;

    always_comb
    begin
        n  = ctr_t'(IMAGE_SIZE);
        h  = ctr_t'(WINDOW_HALF);
        ov = ctr_t'(overlap_width);
        s  = ctr_t'(lateral_shift);
        far_across  = (edge_side == EDGE_LEFT) || (edge_side == EDGE_UP);
        minus_shift = (edge_side == EDGE_LEFT) || (edge_side == EDGE_DOWN);
        if (far_across)
        begin
            across_s1_next[0] = n - ov + h;
            across_s1_next[1] = n - (ov >>> 1);
            across_s1_next[2] = n - h;
        end
        else
        begin
            across_s1_next[0] = h;
            across_s1_next[1] = ov >>> 1;
            across_s1_next[2] = ov - h;
        end
        if (minus_shift)
        begin
            a0_s1_next = h;
            a3_s1_next = half_trunc(n - s);
            a6_s1_next = n - h - s;
        end
        else
        begin
            a0_s1_next = h + s;
            a3_s1_next = half_trunc(n + s);
            a6_s1_next = n - h;
        end
        d1 = a3_s1_next - a0_s1_next;
        d2 = a6_s1_next - a3_s1_next;
        d1_neg_v = -d1;
        d2_neg_v = -d2;
    end

    always_ff @(posedge clk)
    begin
        across_s1_reg <= across_s1_next;
        a0_s1_reg     <= a0_s1_next;
        a3_s1_reg     <= a3_s1_next;
        a6_s1_reg     <= a6_s1_next;
        d1_neg_s1_reg <= d1[CTR_W-1];
        d2_neg_s1_reg <= d2[CTR_W-1];
        d1_mag_s1_reg <= d1[CTR_W-1] ? d1_neg_v[MAG_W-1:0] : d1[MAG_W-1:0];
        d2_mag_s1_reg <= d2[CTR_W-1] ? d2_neg_v[MAG_W-1:0] : d2[MAG_W-1:0];
        es_s1_reg     <= edge_side;
    end

    // stage 2: thirds of the differences
    logic [DIV3_PROD_W-1:0] p1, p2;
    ctr_t                   q1_mag, q2_mag;

    ctr_t              across_s2_reg [ACROSS_COUNT];
    ctr_t              a0_s2_reg, a3_s2_reg, a6_s2_reg, q1_s2_reg, q2_s2_reg;
    logic [EDGE_W-1:0] es_s2_reg;

    always_comb
    begin
        p1 = DIV3_PROD_W'(d1_mag_s1_reg) * DIV3_PROD_W'(DIV3_MULT);
        p2 = DIV3_PROD_W'(d2_mag_s1_reg) * DIV3_PROD_W'(DIV3_MULT);
        q1_mag = ctr_t'(p1[DIV3_SHIFT +: MAG_W]);
        q2_mag = ctr_t'(p2[DIV3_SHIFT +: MAG_W]);
    end

    always_ff @(posedge clk)
    begin
        across_s2_reg <= across_s1_reg;
        a0_s2_reg     <= a0_s1_reg;
        a3_s2_reg     <= a3_s1_reg;
        a6_s2_reg     <= a6_s1_reg;
        q1_s2_reg     <= d1_neg_s1_reg ? -q1_mag : q1_mag;
        q2_s2_reg     <= d2_neg_s1_reg ? -q2_mag : q2_mag;
        es_s2_reg     <= es_s1_reg;
    end

    // stage 3: along positions and per-window centers
    ctr_t along [ALONG_COUNT];
    ctr_t cx_next [REGION_COUNT];
    ctr_t cy_next [REGION_COUNT];
    ctr_t cx_reg [REGION_COUNT];
    ctr_t cy_reg [REGION_COUNT];

    always_comb
    begin
        along[0] = a0_s2_reg;
        along[1] = a0_s2_reg + q1_s2_reg;
        along[2] = a0_s2_reg + (q1_s2_reg <<< 1);
        along[3] = a3_s2_reg;
        along[4] = a3_s2_reg + q2_s2_reg;
        along[5] = a3_s2_reg + (q2_s2_reg <<< 1);
        along[6] = a6_s2_reg;
        for (int i = 0; i < REGION_COUNT; i++)
        begin
            if (es_s2_reg == EDGE_LEFT || es_s2_reg == EDGE_RIGHT)
            begin
                cx_next[i] = across_s2_reg[i % ACROSS_COUNT];
                cy_next[i] = along[i / ACROSS_COUNT];
            end
            else
            begin
                cx_next[i] = along[i % ALONG_COUNT];
                cy_next[i] = across_s2_reg[i / ALONG_COUNT];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg <= cx_next;
        cy_reg <= cy_next;
    end

    assign cx = cx_reg;
    assign cy = cy_reg;

endmodule

[sv/mwrm_cell.sv]
// Window cell: hit test, saturating sum and one stage of the result chain
module mwrm_cell import mwrm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  pix_beat_t  beat,
    input  ctr_t       cx,
    input  ctr_t       cy,
    input  chain_ctl_t ctl,
    input  sum_t       chain_in,
    output sum_t       chain_out
);

    typedef logic signed [CTR_W:0] off_t;

    off_t             dx, dy;
    logic             hit;
    logic [SUM_W:0]   sum_add;
    sum_t             sum_sat, sum_final, sum_next, chain_next;
    sum_t             sum_reg, chain_reg;

    always_comb
    begin
        dx = off_t'(beat.col) - off_t'(cx) + off_t'(WINDOW_HALF);
        dy = off_t'(beat.row) - off_t'(cy) + off_t'(WINDOW_HALF);
        hit = beat.valid &&
              (dx >= off_t'(0)) && (dx < off_t'(2 * WINDOW_HALF)) &&
              (dy >= off_t'(0)) && (dy < off_t'(2 * WINDOW_HALF));
        sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(beat.pix);
        sum_sat = (sum_add > (SUM_W + 1)'(SUM_LIMIT)) ? SUM_W'(SUM_LIMIT) : sum_add[SUM_W-1:0];
        sum_final = hit ? sum_sat : sum_reg;
        sum_next = (beat.valid && beat.last) ? '0 : sum_final;
        if (ctl.load)
            chain_next = sum_final;
        else if (ctl.shift)
            chain_next = chain_in;
        else
            chain_next = chain_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else
            sum_reg <= sum_next;
    end

    always_ff @(posedge clk)
    begin
        chain_reg <= chain_next;
    end

    assign chain_out = chain_reg;

endmodule

[sv/mwrm_mean.sv]
// Rounded mean: reciprocal multiply stage and output register
module mwrm_mean import mwrm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  drain_item_t        item,
    output logic               item_ready,
    mwrm_result_if.source      result_out
);

    localparam int PROD_W = MEAN_SHIFT + PIX_W;

    logic [PROD_W-1:0] prod;
    logic              ready_b, adv_a, adv_b;

    logic              a_valid_reg;
    logic [PIX_W-1:0]  a_mean_reg;
    logic [IDX_W-1:0]  a_index_reg;
    logic              a_last_reg;

    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_mean_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic              out_last_reg;

    always_comb
    begin
        // sum + area/2 must not wrap
        prod = PROD_W'({1'b0, item.sum} + (SUM_W + 1)'(WIN_AREA / 2)) * PROD_W'(MEAN_MULT);
        ready_b    = !out_valid_reg || result_out.ready;
        item_ready = !a_valid_reg || ready_b;
        adv_a      = item.valid && item_ready;
        adv_b      = a_valid_reg && ready_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
                a_valid_reg <= item.valid;
            if (ready_b)
                out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            a_mean_reg  <= prod[MEAN_SHIFT +: PIX_W];
            a_index_reg <= item.index;
            a_last_reg  <= item.last;
        end
        if (adv_b)
        begin
            out_mean_reg  <= a_mean_reg;
            out_index_reg <= a_index_reg;
            out_last_reg  <= a_last_reg;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.region_mean  = out_mean_reg;
    assign result_out.region_index = out_index_reg;
    assign result_out.last_region  = out_last_reg;

endmodule

[tb/sv/multi_window_region_mean_checker.sv]
// Checker: predicts the 21 region means of each plane and compares them with the block's results
module multi_window_region_mean_checker import mwrm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mwrm_pixel_if                 pixel_ch,
    mwrm_result_if                result_ch,
    output int                    fail_count,
    output int                    pending_count
);

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [PIX_W-1:0] mean;
        logic             last;
    } region_mean_t;

    logic [EDGE_W-1:0]  edge_sel = EDGE_RESET;
    logic [OVL_W-1:0]   overlap  = OVL_RESET;
    logic [SHIFT_W-1:0] shift    = SHIFT_RESET;
    int                 col_pos;
    int                 row_pos;
    longint             window_sum [REGION_COUNT];
    int                 center_x   [REGION_COUNT];
    int                 center_y   [REGION_COUNT];
    region_mean_t       expected_means [$];
    int                 errors;

    function automatic void fill_along(input int a0, input int a3, input int a6,
                                       output int a [ALONG_COUNT]);
        a[0] = a0;
        a[3] = a3;
        a[6] = a6;
        a[1] = (a3 - a0) / 3 + a0;
        a[2] = (a3 - a0) / 3 * 2 + a0;
        a[4] = (a6 - a3) / 3 + a3;
        a[5] = (a6 - a3) / 3 * 2 + a3;
    endfunction

    function automatic void place_windows();
        int across [ACROSS_COUNT];
        int along  [ALONG_COUNT];
        int ov;
        int s;
        ov = int'(overlap);
        s  = int'(shift);
        if (edge_sel == EDGE_LEFT || edge_sel == EDGE_UP)
        begin
            across[0] = IMAGE_SIZE - ov + WINDOW_HALF;
            across[1] = IMAGE_SIZE - ov / 2;
            across[2] = IMAGE_SIZE - WINDOW_HALF;
        end
        else
        begin
            across[0] = WINDOW_HALF;
            across[1] = ov / 2;
            across[2] = ov - WINDOW_HALF;
        end
        if (edge_sel == EDGE_LEFT || edge_sel == EDGE_DOWN)
            fill_along(WINDOW_HALF, (IMAGE_SIZE - s) / 2, IMAGE_SIZE - WINDOW_HALF - s, along);
        else
            fill_along(WINDOW_HALF + s, (IMAGE_SIZE + s) / 2, IMAGE_SIZE - WINDOW_HALF, along);
        if (edge_sel == EDGE_LEFT || edge_sel == EDGE_RIGHT)
        begin
            for (int r = 0; r < ALONG_COUNT; r++)
                for (int c = 0; c < ACROSS_COUNT; c++)
                begin
                    center_x[r * ACROSS_COUNT + c] = across[c];
                    center_y[r * ACROSS_COUNT + c] = along[r];
                end
        end
        else
        begin
            for (int r = 0; r < ACROSS_COUNT; r++)
                for (int c = 0; c < ALONG_COUNT; c++)
                begin
                    center_y[r * ALONG_COUNT + c] = across[r];
                    center_x[r * ALONG_COUNT + c] = along[c];
                end
        end
    endfunction

    function automatic void take_pixel(input logic [PIX_W-1:0] value, input logic last);
        longint       total;
        region_mean_t item;
        for (int i = 0; i < REGION_COUNT; i++)
        begin
            if (col_pos >= center_x[i] - WINDOW_HALF && col_pos <= center_x[i] + WINDOW_HALF - 1
                && row_pos >= center_y[i] - WINDOW_HALF
                && row_pos <= center_y[i] + WINDOW_HALF - 1)
            begin
                total = window_sum[i] + longint'(value);
                window_sum[i] = (total > SUM_LIMIT) ? SUM_LIMIT : total;
            end
        end
        if (last)
        begin
            for (int i = 0; i < REGION_COUNT; i++)
            begin
                item.index = IDX_W'(i);
                item.mean  = PIX_W'((window_sum[i] + WIN_AREA / 2) / WIN_AREA);
                item.last  = (i == REGION_COUNT - 1);
                expected_means.push_back(item);
                window_sum[i] = 0;
            end
            col_pos = 0;
            row_pos = 0;
        end
        else
        begin
            col_pos++;
            if (col_pos >= IMAGE_SIZE)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= IMAGE_SIZE)
                    row_pos = 0;
            end
        end
    endfunction

    function automatic void compare_field(input string field, input logic [PIX_W-1:0] want,
                                          input logic [PIX_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endfunction

    function automatic void check_result();
        region_mean_t want;
        if (expected_means.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected transaction: expected none, actual index %0d mean %0d",
                     $time, result_ch.region_index, result_ch.region_mean);
            return;
        end
        want = expected_means.pop_front();
        compare_field("region_index", PIX_W'(want.index), PIX_W'(result_ch.region_index));
        compare_field("region_mean", want.mean, result_ch.region_mean);
        compare_field("last_region", PIX_W'(want.last), PIX_W'(result_ch.last_region));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_sel = EDGE_RESET;
            overlap  = OVL_RESET;
            shift    = SHIFT_RESET;
            col_pos  = 0;
            row_pos  = 0;
            foreach (window_sum[i])
                window_sum[i] = 0;
            expected_means.delete();
            place_windows();
        end
        else
        begin
            if (pixel_ch.valid && pixel_ch.ready)
                take_pixel(pixel_ch.pixel_value, pixel_ch.plane_end);
            if (result_ch.valid && result_ch.ready)
                check_result();
            // a write applies to pixels after it
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_EDGE_SIDE:     edge_sel = cfg_data[EDGE_W-1:0];
                    CFG_OVERLAP_WIDTH: overlap  = cfg_data[OVL_W-1:0];
                    CFG_LATERAL_SHIFT: shift    = cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
                place_windows();
            end
        end
        pending_count <= expected_means.size();
        fail_count    <= errors;
    end

endmodule

[tb/sv/multi_window_region_mean_top_test.sv]
// Testbench top: clock, reset, pixel stimulus and verdict for the multi-window region mean block
module multi_window_region_mean_top_test import mwrm_pkg::*;
    ;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int STEADY_PIXELS = 24;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  steady;
    int                    fail_count;
    int                    pending_count;
    int                    cycle_count;

    mwrm_pixel_if  pixel_ch ();
    mwrm_result_if result_ch ();

    multi_window_region_mean_top dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel_in   (pixel_ch),
        .result_out (result_ch)
    );

    multi_window_region_mean_checker mean_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_ch      (pixel_ch),
        .result_ch     (result_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        result_ch.ready <= steady || ($urandom_range(99) >= 35);

    function automatic logic [PIX_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(7);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return PIX_W'($urandom);
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_settings(input logic [EDGE_W-1:0] side, input logic [OVL_W-1:0] ov,
                                  input logic [SHIFT_W-1:0] s);
        write_register(CFG_EDGE_SIDE, CFG_DATA_W'(side));
        write_register(CFG_OVERLAP_WIDTH, CFG_DATA_W'(ov));
        write_register(CFG_LATERAL_SHIFT, CFG_DATA_W'(s));
    endtask

    task automatic random_settings(input int kind);
        logic [EDGE_W-1:0]  side;
        logic [OVL_W-1:0]   ov;
        logic [SHIFT_W-1:0] s;
        int                 pick;
        side = EDGE_W'($urandom);
        ov   = OVL_W'($urandom);
        s    = SHIFT_W'($urandom);
        if (kind == 1)
        begin
            pick = $urandom_range(3);
            if (pick == 0)
                ov = '0;
            else if (pick == 1)
                ov = OVL_W'(20);
            else if (pick == 2)
                ov = OVL_W'(1900);
            else
                ov = '1;
            pick = $urandom_range(2);
            if (pick == 0)
                s = '0;
            else if (pick == 1)
                s = SHIFT_W'(900);
            else
                s = '1;
        end
        else if (kind == 2)
        begin
            // windows near the top left corner, reached by short planes
            side = $urandom_range(1) ? EDGE_RIGHT : EDGE_DOWN;
            ov   = OVL_W'($urandom_range(60));
            s    = SHIFT_W'($urandom_range(30));
        end
        write_settings(side, ov, s);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] value, input logic last);
        while (!steady && $urandom_range(99) < 35)
        begin
            pixel_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_ch.valid       <= 1'b1;
        pixel_ch.pixel_value <= value;
        pixel_ch.plane_end   <= last;
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_plane();
        int length;
        length = $urandom_range(5, 1);
        for (int i = 0; i < length; i++)
            send_pixel(pick_value(), i == length - 1);
    endtask

    task automatic settle();
        pixel_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_EDGE_SIDE;
        cfg_data             = '0;
        steady               = 1'b0;
        pixel_ch.valid       = 1'b0;
        pixel_ch.pixel_value = '0;
        pixel_ch.plane_end   = 1'b0;
        result_ch.ready      = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-pixel planes back to back under the reset settings
        send_pixel('1, 1'b1);
        send_pixel('0, 1'b1);
        settle();

        // strip of zero width: windows on, half off or fully off the plane
        write_settings(EDGE_RIGHT, '0, '0);
        repeat (19) send_pixel('1, 1'b0);
        send_pixel(PIX_W'(16'h8000), 1'b1);
        settle();

        write_register(CFG_SPARE, '1);
        send_pixel(PIX_W'(1), 1'b1);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            steady <= (phase == 4 || phase == 5);
            random_settings(phase % 4);
            repeat (2) send_plane();
        end

        // one plane with no idling on either side, three windows in the top left corner
        settle();
        write_settings(EDGE_DOWN, OVL_W'(20), '0);
        steady <= 1'b1;
        for (int i = 0; i < STEADY_PIXELS; i++)
            send_pixel(pick_value(), i == STEADY_PIXELS - 1);
        settle();
        steady <= 1'b0;

        // pixels with no plane end give no results
        repeat (5) send_pixel(pick_value(), 1'b0);
        pixel_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
